### hw/rtl/nbc_pkg.sv
package nbc_pkg;

  localparam int NEIGHBORS_DEF     = 8;
  localparam int HISTORY_DEPTH_DEF = 16;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_STABLE_LENGTH   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_QUIET_THRESHOLD = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BASE_LEVEL_X    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_BASE_LEVEL_Y    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_BASE_LEVEL_Z    = 3'd4;

  localparam logic [4:0] STABLE_LENGTH_RST = 5'd8;

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [15:0] VAL_MAX = 16'hFFFF;

  typedef struct packed {
    logic               req_type;
    logic [2:0]         neighbor_index;
    logic [15:0]        neighbor_state;
    logic [15:0]        neighbor_value;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [15:0]        magnitude;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] background_x;
    logic signed [15:0] background_y;
    logic signed [15:0] background_z;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OWR,
    ST_OSCAN,
    ST_CHK,
    ST_MEAN,
    ST_BASE,
    ST_NSEL,
    ST_NSCAN,
    ST_NAPPLY,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/neighbor_background_compensator.sv
// A report word updates one neighbor record. A tick word scans the own history, then the
// history of each changed neighbor with a nonzero state; the active length bounds each
// scan. The shared restoring divider forms the means, and the history is read one row per
// cycle. A stalled result side holds the finished word until it can be loaded.
// One word in flight; the next word is taken while a result waits in the output register.
// Reset clears the control and per-neighbor state, then a clearing pass zeroes the memories.
module neighbor_background_compensator #(
  parameter int NEIGHBORS     = nbc_pkg::NEIGHBORS_DEF,
  parameter int HISTORY_DEPTH = nbc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  nbc_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output nbc_pkg::out_word_t         out_data,
  input  logic                       cfg_we,
  input  logic [nbc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [nbc_pkg::CFG_DW-1:0] cfg_wdata
);
  import nbc_pkg::*;

  localparam int LW   = $clog2(HISTORY_DEPTH + 1);
  localparam int OAW  = $clog2(HISTORY_DEPTH);
  localparam int NDEP = NEIGHBORS * HISTORY_DEPTH;
  localparam int NAW  = (NDEP > 2) ? $clog2(NDEP) : 1;
  localparam int NIW  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int SW   = 16 + LW;
  localparam logic [NAW:0] HD_N   = (NAW + 1)'(HISTORY_DEPTH);
  localparam logic [6:0]   HD_7   = 7'(HISTORY_DEPTH);
  localparam logic [5:0]   NB_6   = 6'(NEIGHBORS);

  // configuration
  logic [4:0]  stable_length_r;
  logic [15:0] quiet_threshold_r;
  logic [15:0] base_level_r [3];

  // control
  state_t          state_r, state_nxt;
  logic [NAW-1:0]  clr_r, clr_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   own_slot_r, own_slot_nxt;
  logic [LW-1:0]   k_r, k_nxt;
  logic            pend_r, pend_nxt;
  logic [NIW-1:0]  i_r, i_nxt;
  logic [NAW-1:0]  nbase_r, nbase_nxt;
  logic [1:0]      j_r, j_nxt;
  logic            dpend_r, dpend_nxt;
  logic            changed_r, changed_nxt;
  logic            allz_r, allz_nxt;
  logic            out_valid_r, out_valid_nxt;

  // payload
  in_word_t        tick_r, tick_nxt;
  out_word_t       out_data_r, out_data_nxt;
  logic [15:0]     mn_r, mn_nxt, mx_r, mx_nxt;
  logic [15:0]     range_r, range_nxt;
  logic [SW-1:0]   sum_r [4];
  logic [SW-1:0]   sum_nxt [4];
  logic [15:0]     mean_r [4];
  logic [15:0]     mean_nxt [4];
  logic [15:0]     bmean_r [4];
  logic [15:0]     bmean_nxt [4];
  logic [15:0]     bg_r [3];
  logic [15:0]     bg_nxt [3];

  // per-neighbor records
  logic [15:0]     cur_r [NEIGHBORS];
  logic [15:0]     cur_nxt [NEIGHBORS];
  logic [15:0]     last_r [NEIGHBORS];
  logic [15:0]     last_nxt [NEIGHBORS];
  logic [15:0]     prev_r [NEIGHBORS];
  logic [15:0]     prev_nxt [NEIGHBORS];
  logic [LW-1:0]   nslot_r [NEIGHBORS];
  logic [LW-1:0]   nslot_nxt [NEIGHBORS];
  logic [15:0]     off_r [NEIGHBORS][3];
  logic [15:0]     off_nxt [NEIGHBORS][3];

  // history memories
  logic [63:0]     own_mem [HISTORY_DEPTH];
  logic [15:0]     nb_mem [NDEP];
  logic            own_we, nb_we;
  logic [OAW-1:0]  own_waddr, own_raddr;
  logic [63:0]     own_wdata, own_rdata_r;
  logic [NAW-1:0]  nb_waddr, nb_raddr;
  logic [15:0]     nb_wdata, nb_rdata_r;

  // divider
  logic            div_start, div_done;
  logic [15:0]     div_q;

  logic            in_accept;
  logic [6:0]      sl7, len7;
  logic [LW-1:0]   slot;
  logic [15:0]     sample, jump;
  logic [NIW-1:0]  ridx;

  nbc_div #(.SW(SW), .LW(LW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[j_r]),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_length_r   <= STABLE_LENGTH_RST;
      quiet_threshold_r <= '0;
      for (int b = 0; b < 3; b++) base_level_r[b] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STABLE_LENGTH:   stable_length_r   <= cfg_wdata[4:0];
        REG_QUIET_THRESHOLD: quiet_threshold_r <= cfg_wdata;
        REG_BASE_LEVEL_X:    base_level_r[0]   <= cfg_wdata;
        REG_BASE_LEVEL_Y:    base_level_r[1]   <= cfg_wdata;
        REG_BASE_LEVEL_Z:    base_level_r[2]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    sl7 = {2'b00, stable_length_r};
    if (sl7 == 7'd0) begin
      len7 = 7'd1;
    end else if (sl7 > HD_7) begin
      len7 = HD_7;
    end else begin
      len7 = sl7;
    end
  end

  always_comb begin
    jump = (mean_r[3] > bmean_r[3]) ? (mean_r[3] - bmean_r[3]) : (bmean_r[3] - mean_r[3]);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    len_nxt       = len_r;
    own_slot_nxt  = own_slot_r;
    k_nxt         = k_r;
    pend_nxt      = 1'b0;
    i_nxt         = i_r;
    nbase_nxt     = nbase_r;
    j_nxt         = j_r;
    dpend_nxt     = dpend_r;
    changed_nxt   = changed_r;
    allz_nxt      = allz_r;
    out_valid_nxt = out_valid_r && out_stall;
    tick_nxt      = tick_r;
    out_data_nxt  = out_data_r;
    mn_nxt        = mn_r;
    mx_nxt        = mx_r;
    range_nxt     = range_r;
    sum_nxt       = sum_r;
    mean_nxt      = mean_r;
    bmean_nxt     = bmean_r;
    bg_nxt        = bg_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    prev_nxt      = prev_r;
    nslot_nxt     = nslot_r;
    off_nxt       = off_r;
    own_we        = 1'b0;
    own_waddr     = '0;
    own_wdata     = '0;
    own_raddr     = OAW'(k_r);
    nb_we         = 1'b0;
    nb_waddr      = '0;
    nb_wdata      = '0;
    nb_raddr      = NAW'(nbase_r + NAW'(k_r));
    div_start     = 1'b0;
    slot          = '0;
    sample        = '0;
    ridx          = NIW'(in_data.neighbor_index);

    case (state_r)
      ST_CLEAR: begin
        nb_we    = 1'b1;
        nb_waddr = clr_r;
        if ({1'b0, clr_r} < HD_N) begin
          own_we    = 1'b1;
          own_waddr = OAW'(clr_r);
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NAW'(NDEP - 1)) state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_accept) begin
          tick_nxt = in_data;
          len_nxt  = LW'(len7);
          if (in_data.req_type == REQ_TICK) begin
            state_nxt = ST_OWR;
          end else begin
            if ({3'b000, in_data.neighbor_index} < NB_6) begin
              cur_nxt[ridx]  = in_data.neighbor_state;
              last_nxt[ridx] = in_data.neighbor_value;
            end
            state_nxt = ST_DONE;
          end
        end
      end

      ST_OWR: begin
        slot         = (own_slot_r >= len_r) ? '0 : own_slot_r;
        own_we       = 1'b1;
        own_waddr    = OAW'(slot);
        own_wdata    = {tick_r.magnitude, tick_r.axis_z, tick_r.axis_y, tick_r.axis_x};
        own_slot_nxt = slot + 1'b1;
        k_nxt        = '0;
        mn_nxt       = VAL_MAX;
        mx_nxt       = '0;
        for (int b = 0; b < 4; b++) sum_nxt[b] = '0;
        state_nxt    = ST_OSCAN;
      end

      ST_OSCAN: begin
        if (k_r < len_r) begin
          pend_nxt = 1'b1;
          k_nxt    = k_r + 1'b1;
        end
        if (pend_r) begin
          for (int b = 0; b < 4; b++) begin
            sum_nxt[b] = sum_r[b] + SW'(own_rdata_r[16*b +: 16]);
          end
          sample = own_rdata_r[63:48];
          if (sample < mn_r) mn_nxt = sample;
          if (sample > mx_r) mx_nxt = sample;
        end
        if (k_r == len_r && !pend_r) begin
          range_nxt   = mx_r - mn_r;
          i_nxt       = '0;
          changed_nxt = 1'b0;
          allz_nxt    = 1'b1;
          state_nxt   = ST_CHK;
        end
      end

      ST_CHK: begin
        if (prev_r[i_r] != cur_r[i_r]) changed_nxt = 1'b1;
        if (cur_r[i_r] != 16'd0) allz_nxt = 1'b0;
        if (i_r == NIW'(NEIGHBORS - 1)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          dpend_nxt = 1'b0;
          state_nxt = ST_MEAN;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end

      ST_MEAN: begin
        if (!dpend_r) begin
          div_start = 1'b1;
          dpend_nxt = 1'b1;
        end else if (div_done) begin
          mean_nxt[j_r] = div_q;
          dpend_nxt     = 1'b0;
          j_nxt         = j_r + 1'b1;
          if (j_r == 2'd3) state_nxt = ST_BASE;
        end
      end

      ST_BASE: begin
        if (!changed_r && range_r < quiet_threshold_r) bmean_nxt = mean_r;
        nbase_nxt = '0;
        state_nxt = ST_NSEL;
      end

      ST_NSEL: begin
        if (prev_r[i_r] == cur_r[i_r]) begin
          state_nxt = ST_NAPPLY;
        end else if (cur_r[i_r] == 16'd0) begin
          // removal: offset stays stored
          for (int b = 0; b < 3; b++) bg_nxt[b] = bg_r[b] - off_r[i_r][b];
          prev_nxt[i_r] = '0;
          state_nxt     = ST_NAPPLY;
        end else begin
          slot            = (nslot_r[i_r] >= len_r) ? '0 : nslot_r[i_r];
          nb_we           = 1'b1;
          nb_waddr        = NAW'(nbase_r + NAW'(slot));
          nb_wdata        = last_r[i_r];
          nslot_nxt[i_r]  = slot + 1'b1;
          k_nxt           = '0;
          mn_nxt          = VAL_MAX;
          mx_nxt          = '0;
          state_nxt       = ST_NSCAN;
        end
      end

      ST_NSCAN: begin
        if (k_r < len_r) begin
          pend_nxt = 1'b1;
          k_nxt    = k_r + 1'b1;
        end
        if (pend_r) begin
          if (nb_rdata_r < mn_r) mn_nxt = nb_rdata_r;
          if (nb_rdata_r > mx_r) mx_nxt = nb_rdata_r;
        end
        if (k_r == len_r && !pend_r) begin
          if ((mx_r - mn_r) < quiet_threshold_r) begin
            if (last_r[i_r] > jump) begin
              for (int b = 0; b < 3; b++) begin
                off_nxt[i_r][b] = mean_r[b] - bmean_r[b];
                bg_nxt[b]       = bg_r[b] + (mean_r[b] - bmean_r[b]);
              end
            end
            prev_nxt[i_r] = cur_r[i_r];
          end
          state_nxt = ST_NAPPLY;
        end
      end

      ST_NAPPLY: begin
        // advance to the next neighbor, or finish after the last one
        if (i_r == NIW'(NEIGHBORS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          i_nxt     = i_r + 1'b1;
          nbase_nxt = NAW'(nbase_r + NAW'(HISTORY_DEPTH));
          state_nxt = ST_NSEL;
        end
      end

      ST_FIN: begin
        if (allz_r) begin
          bg_nxt = base_level_r;
          for (int n = 0; n < NEIGHBORS; n++) prev_nxt[n] = '0;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.background_x = bg_r[0];
          out_data_nxt.background_y = bg_r[1];
          out_data_nxt.background_z = bg_r[2];
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (own_we) own_mem[own_waddr] <= own_wdata;
    own_rdata_r <= own_mem[own_raddr];
  end

  always_ff @(posedge clk) begin
    if (nb_we) nb_mem[nb_waddr] <= nb_wdata;
    nb_rdata_r <= nb_mem[nb_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      own_slot_r  <= '0;
      pend_r      <= 1'b0;
      dpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      for (int b = 0; b < 4; b++) bmean_r[b] <= '0;
      for (int b = 0; b < 4; b++) mean_r[b] <= '0;
      for (int b = 0; b < 3; b++) bg_r[b] <= '0;
      for (int n = 0; n < NEIGHBORS; n++) begin
        cur_r[n]   <= '0;
        last_r[n]  <= '0;
        prev_r[n]  <= '0;
        nslot_r[n] <= '0;
        for (int b = 0; b < 3; b++) off_r[n][b] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      own_slot_r  <= own_slot_nxt;
      pend_r      <= pend_nxt;
      dpend_r     <= dpend_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      bmean_r     <= bmean_nxt;
      mean_r      <= mean_nxt;
      bg_r        <= bg_nxt;
      cur_r       <= cur_nxt;
      last_r      <= last_nxt;
      prev_r      <= prev_nxt;
      nslot_r     <= nslot_nxt;
      off_r       <= off_nxt;
    end
    len_r      <= len_nxt;
    k_r        <= k_nxt;
    nbase_r    <= nbase_nxt;
    changed_r  <= changed_nxt;
    allz_r     <= allz_nxt;
    tick_r     <= tick_nxt;
    out_data_r <= out_data_nxt;
    mn_r       <= mn_nxt;
    mx_r       <= mx_nxt;
    range_r    <= range_nxt;
    sum_r      <= sum_nxt;
  end

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_stall) |=> out_valid_r)
    else $error("finished word not presented");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != ST_IDLE && state_r != ST_CLEAR))
    else $error("accepted word did not start work");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result during clearing pass");

  a_div_in_mean: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_MEAN && dpend_r))
    else $error("divider finished outside mean phase");

endmodule

### hw/rtl/nbc_div.sv
module nbc_div #(
  parameter int SW = 21,
  parameter int LW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW-1:0] dividend,
  input  logic [LW-1:0] divisor,
  output logic          done,
  output logic [15:0]   quotient
);
  import nbc_pkg::*;

  localparam int CW = $clog2(SW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] q_r, q_nxt;
  logic [LW-1:0] dvs_r, dvs_nxt;
  logic [LW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, q_r[SW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // one restoring step per cycle
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = LW'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[SW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[LW-1:0];
        q_nxt   = {q_r[SW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(SW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r[15:0];

endmodule
